@@ rtl/ssqw_pkg.sv @@
// ----------------------------------------------------------------------------
// ssqw_pkg
// Shared types and fixed widths of the single-server queue wait block.
// ----------------------------------------------------------------------------
package ssqw_pkg;

    localparam int SERVICE_W     = 32;
    localparam int TOTAL_W       = 64;
    localparam int DIV_STEPS     = TOTAL_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam logic [SERVICE_W-1:0] SERVICE_RESET = 32'd65536;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DIV    = 4'b0010,
        S_FINISH = 4'b0100,
        S_PUSH   = 4'b1000
    } ssqw_state_t;

    typedef struct packed {
        logic update;
        logic div_step;
        logic finish;
        logic push;
    } ssqw_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } ssqw_status_t;

endpackage

@@ rtl/ssqw_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssqw_ctrl
// Sequencer: accepts a request, runs the mean division at run end, pushes
// the result into the output register.
// ----------------------------------------------------------------------------
module ssqw_ctrl
    import ssqw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         last_arrival,
    input  ssqw_status_t status,
    output logic         in_ready,
    output ssqw_cmd_t    cmd
);

    ssqw_state_t state_reg;
    ssqw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.update = 1'b1;
                    state_next = last_arrival ? S_DIV : S_PUSH;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ssqw_datapath.sv @@
// ----------------------------------------------------------------------------
// ssqw_datapath
// Lindley update, saturating sums, bit-serial mean divider and output register.
// ----------------------------------------------------------------------------
module ssqw_datapath
    import ssqw_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [SERVICE_W-1:0]  cfg_data,
    input  logic [TIME_BITS-1:0]  arrival_time,
    input  logic                  last_arrival,
    input  ssqw_cmd_t             cmd,
    output ssqw_status_t          status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [TIME_BITS-1:0]  wait_time,
    output logic [TIME_BITS-1:0]  mean_wait,
    output logic [COUNT_BITS-1:0] arrivals_seen,
    output logic                  run_done,
    output logic                  saturated
);

    localparam int SUM_W = ((TIME_BITS > SERVICE_W) ? TIME_BITS : SERVICE_W) + 1;

    // run state
    logic [SERVICE_W-1:0]  service_reg;
    logic [TIME_BITS-1:0]  free_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  ovf_reg;

    // result held for the output register
    logic [TIME_BITS-1:0]  res_wait_reg;
    logic [TIME_BITS-1:0]  res_mean_reg;
    logic [COUNT_BITS-1:0] res_count_reg;
    logic                  res_done_reg;
    logic                  res_sat_reg;

    // divider
    logic [TOTAL_W-1:0]    quo_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] divisor_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;

    // output register
    logic                  out_valid_reg;
    logic [TIME_BITS-1:0]  out_wait_reg;
    logic [TIME_BITS-1:0]  out_mean_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic                  out_done_reg;
    logic                  out_sat_reg;

    logic                  early;
    logic [TIME_BITS-1:0]  wait_val;
    logic [TIME_BITS-1:0]  base;
    logic [SUM_W-1:0]      free_sum;
    logic                  free_ovf;
    logic [TIME_BITS-1:0]  free_next;
    logic [TOTAL_W:0]      total_sum;
    logic                  total_ovf;
    logic [TOTAL_W-1:0]    total_next;
    logic                  count_ovf;
    logic [COUNT_BITS-1:0] count_next;
    logic                  ovf_next;
    logic [COUNT_BITS:0]   trial;
    logic                  trial_ge;
    logic                  mean_ovf;
    logic [TIME_BITS-1:0]  mean_val;

    always_comb
    begin
        early      = arrival_time < free_reg;
        wait_val   = early ? (free_reg - arrival_time) : '0;
        base       = early ? free_reg : arrival_time;
        free_sum   = SUM_W'(base) + SUM_W'(service_reg);
        free_ovf   = free_sum[SUM_W-1:TIME_BITS] != '0;
        free_next  = free_ovf ? {TIME_BITS{1'b1}} : free_sum[TIME_BITS-1:0];
        total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(wait_val);
        total_ovf  = total_sum[TOTAL_W];
        total_next = total_ovf ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
        count_ovf  = &count_reg;
        count_next = count_ovf ? count_reg : count_reg + COUNT_BITS'(1);
        ovf_next   = ovf_reg | free_ovf | total_ovf | count_ovf;

        trial      = {rem_reg, quo_reg[TOTAL_W-1]};
        trial_ge   = trial >= {1'b0, divisor_reg};
        mean_ovf   = quo_reg[TOTAL_W-1:TIME_BITS] != '0;
        mean_val   = mean_ovf ? {TIME_BITS{1'b1}} : quo_reg[TIME_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            service_reg <= SERVICE_RESET;
            free_reg    <= '0;
            total_reg   <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                service_reg <= cfg_data;
            end
            if (cmd.update)
            begin
                free_reg  <= free_next;
                total_reg <= total_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
            else if (cmd.finish)
            begin
                // close the run
                free_reg  <= '0;
                total_reg <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            res_wait_reg  <= wait_val;
            res_mean_reg  <= '0;
            res_count_reg <= count_next;
            res_done_reg  <= last_arrival;
            res_sat_reg   <= ovf_next;
            quo_reg       <= total_next;
            rem_reg       <= '0;
            divisor_reg   <= count_next;
            div_cnt_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            // one quotient bit per cycle, restoring
            quo_reg     <= {quo_reg[TOTAL_W-2:0], trial_ge};
            rem_reg     <= trial_ge ? COUNT_BITS'(trial - {1'b0, divisor_reg})
                                    : trial[COUNT_BITS-1:0];
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        else if (cmd.finish)
        begin
            res_mean_reg <= mean_val;
            res_sat_reg  <= res_sat_reg | mean_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_wait_reg  <= res_wait_reg;
            out_mean_reg  <= res_mean_reg;
            out_count_reg <= res_count_reg;
            out_done_reg  <= res_done_reg;
            out_sat_reg   <= res_sat_reg;
        end
    end

    assign status.div_last = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign wait_time     = out_wait_reg;
    assign mean_wait     = out_mean_reg;
    assign arrivals_seen = out_count_reg;
    assign run_done      = out_done_reg;
    assign saturated     = out_sat_reg;

endmodule

@@ rtl/single_server_queue_wait_top.sv @@
// ----------------------------------------------------------------------------
// single_server_queue_wait_top
// Single-server queue with fixed service time, Lindley recursion per arrival.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one arrival request: arrival_time
//   and last_arrival. Output channel (out_valid/out_ready) returns one result
//   per request: wait_time, running arrivals_seen, saturated, and on the last
//   arrival of a run run_done with mean_wait.
//   The cfg channel writes service_time; cfg_ready is always high. Write only
//   while no request is in flight.
// Sequence:
//   An ordinary arrival is updated on the accept edge, then pushed into the
//   output register. A closing arrival is updated, then runs the restoring
//   divider, which yields one of the 64 quotient bits of total wait / count
//   per cycle, then saturates the mean in a finish step before the push.
//   Results come out in the cycle after the push.
// Reset:
//   Run state clears and service_time returns to 1.0 (65536).
// Stall:
//   The output register holds a waiting result while the next request is
//   accepted and processed; that one then holds until the register frees.
// ----------------------------------------------------------------------------
module single_server_queue_wait_top
    import ssqw_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SERVICE_W-1:0]  cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_BITS-1:0]  arrival_time,
    input  logic                  last_arrival,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TIME_BITS-1:0]  wait_time,
    output logic [TIME_BITS-1:0]  mean_wait,
    output logic [COUNT_BITS-1:0] arrivals_seen,
    output logic                  run_done,
    output logic                  saturated
);

    ssqw_cmd_t    cmd;
    ssqw_status_t status;

    assign cfg_ready = 1'b1;

    ssqw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .last_arrival (last_arrival),
        .status       (status),
        .in_ready     (in_ready),
        .cmd          (cmd)
    );

    ssqw_datapath #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .arrival_time  (arrival_time),
        .last_arrival  (last_arrival),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .wait_time     (wait_time),
        .mean_wait     (mean_wait),
        .arrivals_seen (arrivals_seen),
        .run_done      (run_done),
        .saturated     (saturated)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (arrivals_seen != '0))
        else $error("result with zero arrival count");

    a_mean_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_done) |-> (mean_wait == '0))
        else $error("mean set on a result that does not close the run");
`endif

endmodule

@@ tb/sv/single_server_queue_wait_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// single_server_queue_wait_top_tb
// Self-checking bench for the single-server queue wait block. Arrival requests
// are driven through the valid/ready input channel and checked against an
// in-bench Lindley predictor. The bench covers directed edge cases, random
// runs under several service times with random stalls on both sides, and a
// closing run of deep queueing back to back with no stalls.
// ----------------------------------------------------------------------------
module single_server_queue_wait_top_tb
    import ssqw_pkg::*;
();

    localparam int TIME_W         = 48;
    localparam int COUNT_W        = 32;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 80;
    localparam logic [TIME_W-1:0]  TIME_TOP = {TIME_W{1'b1}};
    localparam logic [TOTAL_W-1:0] MEAN_CAP = {{(TOTAL_W-TIME_W){1'b0}}, TIME_TOP};

    typedef struct packed {
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  mean_wait;
        logic [COUNT_W-1:0] arrivals_seen;
        logic               run_done;
        logic               saturated;
    } queue_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SERVICE_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [TIME_W-1:0]    arrival_time = '0;
    logic                 last_arrival = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    logic [TIME_W-1:0]    wait_time;
    logic [TIME_W-1:0]    mean_wait;
    logic [COUNT_W-1:0]   arrivals_seen;
    logic                 run_done;
    logic                 saturated;

    // predictor state
    logic [SERVICE_W-1:0] service_cfg = SERVICE_RESET;
    logic [TIME_W-1:0]    server_free = '0;
    logic [TOTAL_W-1:0]   total_wait = '0;
    logic [COUNT_W-1:0]   run_count = '0;
    logic                 run_saturated = 1'b0;

    queue_result_t results_due[$];
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   idle_odds = 0;

    single_server_queue_wait_top #(
        .TIME_BITS  (TIME_W),
        .COUNT_BITS (COUNT_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .arrival_time  (arrival_time),
        .last_arrival  (last_arrival),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .wait_time     (wait_time),
        .mean_wait     (mean_wait),
        .arrivals_seen (arrivals_seen),
        .run_done      (run_done),
        .saturated     (saturated)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // One Lindley step: wait of this arrival, then advance free time, total and count.
    function automatic queue_result_t lindley_step(logic [TIME_W-1:0] arrival, logic last);
        queue_result_t      r;
        logic [TIME_W:0]    next_free;
        logic [TOTAL_W:0]   sum;
        logic [TOTAL_W-1:0] quot;
        r = '0;
        if (arrival < server_free)
        begin
            r.wait_time = server_free - arrival;
            next_free = {1'b0, server_free} + service_cfg;
        end
        else
        begin
            r.wait_time = '0;
            next_free = {1'b0, arrival} + service_cfg;
        end
        if (next_free[TIME_W])
        begin
            server_free = TIME_TOP;
            run_saturated = 1'b1;
        end
        else
            server_free = next_free[TIME_W-1:0];

        sum = {1'b0, total_wait} + r.wait_time;
        if (sum[TOTAL_W])
        begin
            total_wait = '1;
            run_saturated = 1'b1;
        end
        else
            total_wait = sum[TOTAL_W-1:0];

        if (run_count == '1)
            run_saturated = 1'b1;
        else
            run_count = run_count + 1'b1;

        if (last)
        begin
            quot = total_wait / {{(TOTAL_W-COUNT_W){1'b0}}, run_count};
            if (quot > MEAN_CAP)
            begin
                quot = MEAN_CAP;
                run_saturated = 1'b1;
            end
            r.mean_wait = quot[TIME_W-1:0];
        end
        r.arrivals_seen = run_count;
        r.run_done      = last;
        r.saturated     = run_saturated;

        if (last)
        begin
            server_free   = '0;
            total_wait    = '0;
            run_count     = '0;
            run_saturated = 1'b0;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // result checker
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result with no request outstanding: wait_time %0h", wait_time);
                mismatch_count++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("wait_time", want.wait_time, wait_time);
                check_field("mean_wait", want.mean_wait, mean_wait);
                check_field("arrivals_seen", want.arrivals_seen, arrivals_seen);
                check_field("run_done", want.run_done, run_done);
                check_field("saturated", want.saturated, saturated);
            end
        end
    end

    // watchdog: count cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // output back-pressure in random bursts
    initial
    begin : result_stall
        int unsigned n;
        forever
        begin
            @(posedge clk);
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                n = $urandom_range(1, 19);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_arrival(logic [TIME_W-1:0] t, logic last);
        int unsigned gap;
        in_valid     <= 1'b1;
        arrival_time <= t;
        last_arrival <= last;
        do @(posedge clk); while (!in_ready);
        results_due = {results_due, lindley_step(t, last)};
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every outstanding request has its result.
    task automatic wait_drained();
        if (in_valid)
            in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_service(logic [SERVICE_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        service_cfg = value;
    endtask

    task automatic test_first_arrivals();
        // first arrival waits nothing, then queueing and an early arrival
        send_arrival(48'h0, 1'b0);
        send_arrival(48'h0, 1'b0);
        send_arrival(48'h8000, 1'b0);
        send_arrival(48'h4000, 1'b0);
        // closing arrival after the queue empties; mean truncates
        send_arrival(48'h10_0000, 1'b1);
        // run of one arrival
        send_arrival(48'h1234_5678_9ABC, 1'b1);
    endtask

    task automatic test_arrival_extremes();
        // free time saturates at the top of the range
        send_arrival(TIME_TOP, 1'b0);
        send_arrival(TIME_TOP, 1'b0);
        send_arrival(48'hAAAA_AAAA_AAAA, 1'b0);
        send_arrival(48'h5555_5555_5555, 1'b1);
        // flag must clear with the new run
        send_arrival(48'h0, 1'b1);
    endtask

    task automatic test_service_extremes();
        write_service('1);
        send_arrival(48'h0, 1'b0);
        send_arrival(48'h0, 1'b0);
        send_arrival(48'h1, 1'b1);
        write_service(32'd1);
        send_arrival(48'h7FFF_FFFF_FFFF, 1'b0);
        send_arrival(48'h7FFF_FFFF_FFFF, 1'b0);
        send_arrival(48'h0, 1'b1);
        // zero service: server frees at the arrival itself
        write_service('0);
        send_arrival(48'h5, 1'b0);
        send_arrival(48'h5, 1'b0);
        send_arrival(48'h4, 1'b1);
    endtask

    task automatic test_random_runs(int unsigned items);
        int unsigned       sent;
        int unsigned       run_len;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] inc;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_service(32'd1);
                    1: write_service('1);
                    2: write_service(SERVICE_RESET);
                    3: write_service($urandom_range(1, 1 << 20));
                    default: write_service($urandom);
                endcase
            end
            case ($urandom_range(0, 3))
                0: idle_odds = 0;
                1: idle_odds = 3;
                2: idle_odds = 8;
                default: idle_odds = 20;
            endcase
            case ($urandom_range(0, 9))
                8: t = rand_time();
                9: t = TIME_TOP - TIME_W'($urandom_range(0, 1 << 20));
                default: t = TIME_W'($urandom_range(0, 1 << 20));
            endcase
            span = TIME_W'(service_cfg) + 1'b1;
            run_len = $urandom_range(1, 30);
            for (int unsigned i = 0; i < run_len; i++)
            begin
                case ($urandom_range(0, 19))
                    0: t = rand_time();
                    1: t = t - TIME_W'($urandom_range(0, 1 << 18));
                    default:
                    begin
                        // offered load near one, so queues build and drain
                        inc = TIME_W'($urandom) % span;
                        if ($urandom_range(0, 1))
                            inc = inc + TIME_W'($urandom) % span;
                        t = t + inc;
                    end
                endcase
                send_arrival(t, i == run_len - 1);
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
            sent += run_len;
        end
    endtask

    // Waits near the top of the range, back to back with no stalls; the total
    // grows far past the time range while free time stays below its cap.
    task automatic test_deep_queue();
        write_service(32'd1);
        send_arrival(TIME_TOP - 48'd100_000, 1'b0);
        repeat (40)
            send_arrival(48'h0, 1'b0);
        send_arrival(48'h0, 1'b1);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        idle_odds = 4;
        test_first_arrivals();
        test_arrival_extremes();
        test_service_extremes();
        test_random_runs(480);
        idle_odds = 0;
        test_deep_queue();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
